// File: src/mlc_pkg.sv
// shared types, codes and constants of the mip level layout calculator
package mlc_pkg;

  localparam int MAX_LEVELS_DEF = 16;

  localparam int FMT_W    = 3;
  localparam int DIM_W    = 15;
  localparam int DEP_W    = 12;
  localparam int LCNT_W   = 5;
  localparam int LVL_W    = 4;
  localparam int STAT_W   = 2;
  localparam int BLK_W    = 5;
  localparam int ROWB_W   = 17;
  localparam int ROWBI_W  = 18;
  localparam int BYTES_W  = 42;
  localparam int OFF_W    = 43;
  localparam int PROD_W   = 33;

  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 168;
  localparam int M_TUSER_W = STAT_W;
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;

  typedef enum logic [FMT_W-1:0] {
    FMT_NONE   = 3'd0,
    FMT_RGBA   = 3'd1,
    FMT_DXT1   = 3'd2,
    FMT_DXT3   = 3'd3,
    FMT_DXT5   = 3'd4,
    FMT_ETC1   = 3'd5,
    FMT_PVRTC2 = 3'd6,
    FMT_PVRTC4 = 3'd7
  } fmt_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_NOCOMP = 2'd1,
    STAT_RANGE  = 2'd2
  } stat_e;

  typedef enum logic [2:0] {
    REG_FORMAT = 3'd0,
    REG_BASE_W = 3'd1,
    REG_BASE_H = 3'd2,
    REG_BASE_D = 3'd3,
    REG_LCOUNT = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MUL1,
    ST_MUL2,
    ST_STEP,
    ST_FINISH
  } state_e;

  localparam logic [BLK_W-1:0] BLK_RGBA  = 5'd4;
  localparam logic [BLK_W-1:0] BLK_SMALL = 5'd8;
  localparam logic [BLK_W-1:0] BLK_LARGE = 5'd16;
  localparam logic [BLK_W-1:0] BLK_PV2   = 5'd2;
  localparam logic [BLK_W-1:0] BLK_PV4   = 5'd4;

  localparam logic [DIM_W-1:0] PV2_MIN_W = 15'd16;
  localparam logic [DIM_W-1:0] PV_MIN    = 15'd8;
  localparam logic [DIM_W:0]   BLK_ROUND = 16'd3;
  localparam logic [PROD_W+2:0] BIT_ROUND = 36'd7;

  typedef struct packed {
    logic [FMT_W-1:0]  format;
    logic [DIM_W-1:0]  base_width;
    logic [DIM_W-1:0]  base_height;
    logic [DEP_W-1:0]  base_depth;
    logic [LCNT_W-1:0] level_count;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic init;
    logic mul1;
    logic mul2;
    logic halve;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
    logic all_zero;
  } dp_sts_t;

endpackage

// File: src/mlc_regs.sv
// configuration register file behind the apb port
module mlc_regs
  import mlc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_FORMAT: cfg_d.format      = pwdata[FMT_W-1:0];
        REG_BASE_W: cfg_d.base_width  = pwdata[DIM_W-1:0];
        REG_BASE_H: cfg_d.base_height = pwdata[DIM_W-1:0];
        REG_BASE_D: cfg_d.base_depth  = pwdata[DEP_W-1:0];
        REG_LCOUNT: cfg_d.level_count = pwdata[LCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FORMAT: prdata = APB_DW'(cfg_q.format);
      REG_BASE_W: prdata = APB_DW'(cfg_q.base_width);
      REG_BASE_H: prdata = APB_DW'(cfg_q.base_height);
      REG_BASE_D: prdata = APB_DW'(cfg_q.base_depth);
      REG_LCOUNT: prdata = APB_DW'(cfg_q.level_count);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.format      <= FMT_NONE;
      cfg_q.base_width  <= '0;
      cfg_q.base_height <= '0;
      cfg_q.base_depth  <= '0;
      cfg_q.level_count <= LCNT_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/mlc_ctrl.sv
// sequencer: walks the chain one level at a time and drives the datapath
module mlc_ctrl
  import mlc_pkg::*;
#(
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [LVL_W-1:0] level_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dp_cmd_t          cmd_o,
  input  dp_sts_t          sts_i
);

  localparam int CntW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovalid_q, ovalid_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ovalid_d   = ovalid_q & ~out_ready_i;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          cnt_d       = level_i[CntW-1:0];
          state_d     = sts_i.err ? ST_FINISH : ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = (cnt_q == '0) ? ST_FINISH : ST_STEP;
      end
      ST_STEP: begin
        cmd_o.halve = 1'b1;
        if (sts_i.all_zero) begin
          state_d = ST_FINISH;
        end else begin
          cnt_d   = cnt_q - CntW'(1);
          state_d = ST_MUL1;
        end
      end
      ST_FINISH: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

// File: src/mlc_dp.sv
// datapath: level dimensions, per-level sizing multiplies, offset sum, result register
module mlc_dp
  import mlc_pkg::*;
#(
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic [LVL_W-1:0]     level_i,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  output logic [M_TDATA_W-1:0] res_data_o,
  output logic [M_TUSER_W-1:0] res_user_o
);

  logic [DIM_W-1:0]   w_q, h_q;
  logic [DEP_W-1:0]   d_q;
  logic [OFF_W-1:0]   off_q;
  logic [PROD_W-1:0]  prod_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [ROWBI_W-1:0] rowb_q;
  logic [DIM_W-1:0]   rows_q;
  logic [BLK_W-1:0]   blk_q;
  logic [STAT_W-1:0]  stat_q;
  logic               pv4_q;

  logic [M_TDATA_W-1:0] rdata_q;
  logic [M_TUSER_W-1:0] ruser_q;

  fmt_e               fmt;
  logic               is_rgba, is_blk, is_pv, blk8;
  logic [DIM_W:0]     wsum, hsum;
  logic [DIM_W-1:0]   pv_mw, dw, dh;
  logic [ROWBI_W-1:0] rowb_c;
  logic [DIM_W-1:0]   rows_c;
  logic [BLK_W-1:0]   blk_c;
  logic [ROWBI_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_c;
  logic [44:0]        vol_c;
  logic [PROD_W+2:0]  pv_sum;
  logic [BYTES_W-1:0] bytes_c;
  logic [DIM_W-1:0]   hw, hh;
  logic [DEP_W-1:0]   hd;
  logic               all_zero;
  logic [STAT_W-1:0]  stat_c;
  logic [OFF_W-1:0]   off_c;

  assign fmt     = fmt_e'(cfg_i.format);
  assign is_rgba = (fmt == FMT_RGBA);
  assign is_pv   = (fmt == FMT_PVRTC2) || (fmt == FMT_PVRTC4);
  assign is_blk  = !is_rgba && !is_pv && (fmt != FMT_NONE);
  assign blk8    = (fmt == FMT_DXT1) || (fmt == FMT_ETC1);

  assign wsum  = {1'b0, w_q} + BLK_ROUND;
  assign hsum  = {1'b0, h_q} + BLK_ROUND;
  assign pv_mw = (fmt == FMT_PVRTC2) ? PV2_MIN_W : PV_MIN;
  assign dw    = (w_q < pv_mw) ? pv_mw : w_q;
  assign dh    = (h_q < PV_MIN) ? PV_MIN : h_q;

  // pvrtc row size reduces to a shift of the padded width
  always_comb begin
    if (is_rgba) begin
      blk_c  = BLK_RGBA;
      rowb_c = {1'b0, w_q, 2'b00};
      rows_c = h_q;
    end else if (is_blk) begin
      blk_c  = blk8 ? BLK_SMALL : BLK_LARGE;
      rowb_c = blk8 ? {1'b0, wsum[DIM_W:2], 3'b000} : {wsum[DIM_W:2], 4'b0000};
      rows_c = {1'b0, hsum[DIM_W:2]};
    end else if (fmt == FMT_PVRTC2) begin
      blk_c  = BLK_PV2;
      rowb_c = {5'b0, dw[DIM_W-1:2]};
      rows_c = dh;
    end else begin
      blk_c  = BLK_PV4;
      rowb_c = {4'b0, dw[DIM_W-1:1]};
      rows_c = dh;
    end
  end

  assign mul_b  = is_pv ? {3'b000, dw} : rowb_c;
  assign prod_c = PROD_W'(rows_c) * PROD_W'(mul_b);
  assign vol_c  = {33'b0, d_q} * {12'b0, prod_q};
  assign pv_sum = (pv4_q ? {1'b0, prod_q, 2'b00} : {2'b00, prod_q, 1'b0}) + BIT_ROUND;
  assign bytes_c = is_pv ? BYTES_W'(pv_sum[PROD_W+2:3]) : vol_c[BYTES_W-1:0];

  assign hw       = w_q >> 1;
  assign hh       = h_q >> 1;
  assign hd       = d_q >> 1;
  assign all_zero = (hw == '0) && (hh == '0) && (hd == '0);
  assign off_c    = off_q + {1'b0, bytes_q};

  always_comb begin
    if (fmt == FMT_NONE) begin
      stat_c = STAT_NOCOMP;
    end else if (({1'b0, level_i} >= cfg_i.level_count) ||
                 (32'(level_i) >= 32'(MAX_LEVELS))) begin
      stat_c = STAT_RANGE;
    end else begin
      stat_c = STAT_OK;
    end
  end

  assign sts_o.err      = (stat_c != STAT_OK);
  assign sts_o.all_zero = all_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= '0;
      h_q     <= '0;
      d_q     <= '0;
      off_q   <= '0;
      prod_q  <= '0;
      bytes_q <= '0;
      rowb_q  <= '0;
      rows_q  <= '0;
      blk_q   <= '0;
      stat_q  <= '0;
      pv4_q   <= 1'b0;
      rdata_q <= '0;
      ruser_q <= '0;
    end else begin
      if (cmd_i.start) begin
        stat_q <= stat_c;
        pv4_q  <= (fmt == FMT_PVRTC4);
      end
      if (cmd_i.init) begin
        w_q   <= (cfg_i.base_width == '0) ? DIM_W'(1) : cfg_i.base_width;
        h_q   <= (cfg_i.base_height == '0) ? DIM_W'(1) : cfg_i.base_height;
        d_q   <= (cfg_i.base_depth == '0) ? DEP_W'(1) : cfg_i.base_depth;
        off_q <= '0;
      end
      if (cmd_i.mul1) begin
        prod_q <= prod_c;
        rowb_q <= rowb_c;
        rows_q <= rows_c;
        blk_q  <= blk_c;
      end
      if (cmd_i.mul2) begin
        bytes_q <= bytes_c;
      end
      if (cmd_i.halve) begin
        if (all_zero) begin
          w_q <= '0;
          h_q <= '0;
          d_q <= '0;
        end else begin
          w_q   <= (hw == '0) ? DIM_W'(1) : hw;
          h_q   <= (hh == '0) ? DIM_W'(1) : hh;
          d_q   <= (hd == '0) ? DEP_W'(1) : hd;
          off_q <= off_c;
        end
      end
      if (cmd_i.load_out) begin
        ruser_q <= stat_q;
        if (stat_q != STAT_OK) begin
          rdata_q <= '0;
        end else begin
          rdata_q <= {4'b0000, off_q, bytes_q, rows_q, rowb_q[ROWB_W-1:0], blk_q,
                      d_q, h_q, w_q};
        end
      end
    end
  end

  assign res_data_o = rdata_q;
  assign res_user_o = ruser_q;

endmodule

// File: src/mip_level_layout_calc.sv
// top level of the mip level layout calculator
//
//  channel   dir  handshake                 content
//  s_axis    in   s_axis_tvalid/tready      one level request per beat
//  m_axis    out  m_axis_tvalid/tready      one level layout per beat
//  apb       in   psel/penable/pwrite       format, base size, level count
//
// a request for level n runs the two chained sizing multiplies for each level up to n,
// with a halving step between levels; a request in error skips them all.
// a new request is taken once the previous one is sequenced, while its result
// may still wait in the output register; a stalled result holds the sequencer.
// reset clears the registers to format none and level count 1.
module mip_level_layout_calc
  import mlc_pkg::*;
#(
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [3:0] level_index
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [14:0] level_width, [29:15] level_height, [41:30] level_depth,
  // [46:42] block_bytes, [63:47] row_bytes, [78:64] row_count,
  // [120:79] level_bytes, [163:121] level_offset
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [M_TUSER_W-1:0] m_axis_tuser,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  cfg_t             cfg;
  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [LVL_W-1:0] level;

  assign level = s_axis_tdata[LVL_W-1:0];

  mlc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mlc_ctrl #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .level_i     (level),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mlc_dp #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .level_i    (level),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_data_o (m_axis_tdata),
    .res_user_o (m_axis_tuser)
  );

endmodule
